// ===== rtl/lpc_pkg.sv =====
package lpc_pkg;

    // default geometry
    localparam int NUM_PAGES_DEF  = 8;
    localparam int PAGE_BYTES_DEF = 256;
    localparam int ADDR_BITS_DEF  = 23;

    // action codes of an input word
    typedef enum logic [2:0] {
        ACT_READ_BYTE  = 3'd0,
        ACT_READ_WORD  = 3'd1,
        ACT_WRITE_BYTE = 3'd2,
        ACT_WRITE_WORD = 3'd3,
        ACT_FILL_BYTE  = 3'd4
    } action_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DATA
    } state_t;

    // recency update request to the directory
    typedef struct packed {
        logic touch;   // read hit: move entry to most recent
        logic claim;   // read miss: take free or least recent entry
    } dir_cmd_t;

endpackage

// ===== rtl/lpc_bank.sv =====
module lpc_bank #(
    parameter int DEPTH = lpc_pkg::NUM_PAGES_DEF * lpc_pkg::PAGE_BYTES_DEF / 2,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lpc_dir.sv =====
module lpc_dir #(
    parameter int NUM_PAGES = lpc_pkg::NUM_PAGES_DEF,
    parameter int PW        = lpc_pkg::ADDR_BITS_DEF - $clog2(lpc_pkg::PAGE_BYTES_DEF),
    parameter int EW        = $clog2(NUM_PAGES)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [PW-1:0]    page,
    input  lpc_pkg::dir_cmd_t cmd,
    output logic             hit,
    output logic [EW-1:0]    hit_entry,
    output logic [EW-1:0]    most_recent
);

    localparam int CW = $clog2(NUM_PAGES + 1);

    logic [PW-1:0] tag_reg   [NUM_PAGES];
    logic [PW-1:0] tag_next  [NUM_PAGES];
    logic [EW-1:0] older_reg [NUM_PAGES];
    logic [EW-1:0] older_next[NUM_PAGES];
    logic [EW-1:0] newer_reg [NUM_PAGES];
    logic [EW-1:0] newer_next[NUM_PAGES];
    logic [EW-1:0] mr_reg, mr_next;
    logic [EW-1:0] lr_reg, lr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [EW-1:0] e;
    logic [EW-1:0] n;

    // tag match over entries in use, lowest index wins
    always_comb
    begin
        hit       = 1'b0;
        hit_entry = '0;
        for (int i = NUM_PAGES - 1; i >= 0; i--)
        begin
            if ((CW'(i) < count_reg) && (tag_reg[i] == page))
            begin
                hit       = 1'b1;
                hit_entry = EW'(i);
            end
        end
    end

    // recency list update, statements in list order
    always_comb
    begin
        tag_next   = tag_reg;
        older_next = older_reg;
        newer_next = newer_reg;
        mr_next    = mr_reg;
        lr_next    = lr_reg;
        count_next = count_reg;
        e          = hit_entry;
        n          = '0;
        if (cmd.touch)
        begin
            if (e != mr_reg)
            begin
                if (e == lr_reg)
                begin
                    n             = newer_next[e];
                    older_next[n] = n;
                    lr_next       = n;
                end
                else
                begin
                    older_next[newer_next[e]] = older_next[e];
                    newer_next[older_next[e]] = newer_next[e];
                end
                newer_next[e]       = e;
                older_next[e]       = mr_next;
                newer_next[mr_next] = e;
                mr_next             = e;
            end
        end
        else if (cmd.claim)
        begin
            if (count_reg < CW'(NUM_PAGES))
            begin
                e          = count_reg[EW-1:0];
                count_next = count_reg + CW'(1);
            end
            else
            begin
                e             = lr_reg;
                n             = newer_next[e];
                older_next[n] = n;
                lr_next       = n;
            end
            tag_next[e]         = page;
            newer_next[e]       = e;
            older_next[e]       = mr_next;
            newer_next[mr_next] = e;
            mr_next             = e;
        end
    end

    // tags are only read for entries in use
    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PAGES; i++)
            begin
                older_reg[i] <= '0;
                newer_reg[i] <= '0;
            end
            mr_reg    <= '0;
            lr_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            older_reg <= older_next;
            newer_reg <= newer_next;
            mr_reg    <= mr_next;
            lr_reg    <= lr_next;
            count_reg <= count_next;
        end
    end

    assign most_recent = mr_reg;

endmodule

// ===== rtl/lru_page_cache.sv =====
// fully associative write-through page cache with least recently used
// replacement. each accepted word gives exactly one result word: a read hit
// returns the byte or little-endian word (the high byte wraps to offset 0 at
// the last offset of a page) and makes the page most recent; a read miss
// claims a free entry or the least recent one, makes it most recent and asks
// for fetch_page, after which the host sends fill bytes (they land in the most
// recent entry) and retries the read. writes always show up on the mem_* fields
// and update a cached copy without touching recency. unused action codes give an
// all-zero result. an item passes through a lookup state (tag compare,
// recency update, page memory access) and a data state in which the page
// memory's registered read data goes to the output register; a new word is
// taken when idle or as that result is loaded. the page store comes up
// with unknown contents; reading a byte never filled or written is not defined.
module lru_page_cache #(
    parameter int NUM_PAGES  = lpc_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BYTES = lpc_pkg::PAGE_BYTES_DEF,
    parameter int ADDR_BITS  = lpc_pkg::ADDR_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         action,
    input  logic [ADDR_BITS-1:0]               address,
    input  logic [15:0]                        write_data,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [15:0]                        read_data,
    output logic                               hit,
    output logic                               fetch_request,
    output logic [ADDR_BITS-$clog2(PAGE_BYTES)-1:0] fetch_page,
    output logic                               mem_write,
    output logic [ADDR_BITS-1:0]               mem_write_address,
    output logic [15:0]                        mem_write_data,
    output logic                               mem_write_word
);

    localparam int OW    = $clog2(PAGE_BYTES);      // page offset bits
    localparam int PW    = ADDR_BITS - OW;          // page number bits
    localparam int EW    = $clog2(NUM_PAGES);       // entry index bits
    localparam int IW    = OW - 1;                  // index within a bank
    localparam int BAW   = EW + IW;                 // bank address bits
    localparam int DEPTH = NUM_PAGES * PAGE_BYTES / 2;

    lpc_pkg::state_t state_reg, state_next;

    // accepted word
    logic [2:0]           action_reg;
    logic [ADDR_BITS-1:0] address_reg;
    logic [15:0]          wdata_reg;
    logic                 hit_reg;

    // output register
    logic                 out_valid_reg;
    logic [15:0]          read_data_reg;
    logic                 hit_out_reg;
    logic                 fetch_request_reg;
    logic [PW-1:0]        fetch_page_reg;
    logic                 mem_write_reg;
    logic [ADDR_BITS-1:0] mem_write_address_reg;
    logic [15:0]          mem_write_data_reg;
    logic                 mem_write_word_reg;

    // decode
    logic          is_read, is_word_read, is_write, is_word_write, is_fill;
    logic [OW-1:0] offs, offs_up;
    logic [PW-1:0] page;
    logic          in_take, out_load, lookup;

    // directory
    lpc_pkg::dir_cmd_t dir_cmd;
    logic              dir_hit;
    logic [EW-1:0]     dir_entry, dir_mr;

    // page memory banks, even and odd offsets
    logic [EW-1:0]  mem_entry;
    logic [IW-1:0]  even_idx, odd_idx;
    logic           even_we, odd_we, bank_re;
    logic [7:0]     even_wd, odd_wd, even_rd, odd_rd;
    logic [7:0]     lo_byte, hi_byte;

    assign offs    = address_reg[OW-1:0];
    assign offs_up = offs + OW'(1);   // wraps inside the page
    assign page    = address_reg[ADDR_BITS-1:OW];

    always_comb
    begin
        is_read       = 1'b0;
        is_word_read  = 1'b0;
        is_write      = 1'b0;
        is_word_write = 1'b0;
        is_fill       = 1'b0;
        case (action_reg)
            lpc_pkg::ACT_READ_BYTE:
            begin
                is_read = 1'b1;
            end
            lpc_pkg::ACT_READ_WORD:
            begin
                is_read      = 1'b1;
                is_word_read = 1'b1;
            end
            lpc_pkg::ACT_WRITE_BYTE:
            begin
                is_write = 1'b1;
            end
            lpc_pkg::ACT_WRITE_WORD:
            begin
                is_write      = 1'b1;
                is_word_write = 1'b1;
            end
            lpc_pkg::ACT_FILL_BYTE:
            begin
                is_fill = 1'b1;
            end
            default:
            begin
                is_read = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        lookup     = 1'b0;
        case (state_reg)
            lpc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = lpc_pkg::ST_LOOKUP;
                end
            end
            lpc_pkg::ST_LOOKUP:
            begin
                lookup     = 1'b1;
                state_next = lpc_pkg::ST_DATA;
            end
            lpc_pkg::ST_DATA:
            begin
                // result leaves as the next word comes in
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    in_ready   = 1'b1;
                    state_next = in_valid ? lpc_pkg::ST_LOOKUP : lpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpc_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_take = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg  <= action;
            address_reg <= address;
            wdata_reg   <= write_data;
        end
        if (lookup)
        begin
            hit_reg <= dir_hit;
        end
    end

    // directory: tags and recency list
    assign dir_cmd.touch = lookup && is_read && dir_hit;
    assign dir_cmd.claim = lookup && is_read && !dir_hit;

    lpc_dir #(
        .NUM_PAGES (NUM_PAGES),
        .PW        (PW),
        .EW        (EW)
    ) u_dir (
        .clk         (clk),
        .rst_n       (rst_n),
        .page        (page),
        .cmd         (dir_cmd),
        .hit         (dir_hit),
        .hit_entry   (dir_entry),
        .most_recent (dir_mr)
    );

    // bank addressing: the odd byte of a word is always at offs>>1, the even
    // byte moves up one slot when the word starts on an odd offset
    assign mem_entry = is_fill ? dir_mr : dir_entry;
    assign odd_idx   = offs[OW-1:1];
    assign even_idx  = offs[0] ? offs_up[OW-1:1] : offs[OW-1:1];

    assign even_we = lookup && ((is_write && dir_hit && (is_word_write || !offs[0]))
                                || (is_fill && !offs[0]));
    assign odd_we  = lookup && ((is_write && dir_hit && (is_word_write || offs[0]))
                                || (is_fill && offs[0]));
    assign even_wd = offs[0] ? wdata_reg[15:8] : wdata_reg[7:0];
    assign odd_wd  = offs[0] ? wdata_reg[7:0] : wdata_reg[15:8];
    assign bank_re = lookup && is_read && dir_hit;

    lpc_bank #(
        .DEPTH (DEPTH),
        .AW    (BAW)
    ) u_even (
        .clk   (clk),
        .we    (even_we),
        .waddr ({mem_entry, even_idx}),
        .wdata (even_wd),
        .re    (bank_re),
        .raddr ({mem_entry, even_idx}),
        .rdata (even_rd)
    );

    lpc_bank #(
        .DEPTH (DEPTH),
        .AW    (BAW)
    ) u_odd (
        .clk   (clk),
        .we    (odd_we),
        .waddr ({mem_entry, odd_idx}),
        .wdata (odd_wd),
        .re    (bank_re),
        .raddr ({mem_entry, odd_idx}),
        .rdata (odd_rd)
    );

    assign lo_byte = offs[0] ? odd_rd : even_rd;
    assign hi_byte = offs[0] ? even_rd : odd_rd;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (is_read && hit_reg)
            begin
                read_data_reg <= is_word_read ? {hi_byte, lo_byte} : {8'h00, lo_byte};
            end
            else
            begin
                read_data_reg <= '0;
            end
            hit_out_reg           <= is_read && hit_reg;
            fetch_request_reg     <= is_read && !hit_reg;
            fetch_page_reg        <= (is_read && !hit_reg) ? page : '0;
            mem_write_reg         <= is_write;
            mem_write_address_reg <= is_write ? address_reg : '0;
            if (is_word_write)
            begin
                mem_write_data_reg <= wdata_reg;
            end
            else if (is_write)
            begin
                mem_write_data_reg <= {8'h00, wdata_reg[7:0]};
            end
            else
            begin
                mem_write_data_reg <= '0;
            end
            mem_write_word_reg <= is_word_write;
        end
    end

    assign out_valid         = out_valid_reg;
    assign read_data         = read_data_reg;
    assign hit               = hit_out_reg;
    assign fetch_request     = fetch_request_reg;
    assign fetch_page        = fetch_page_reg;
    assign mem_write         = mem_write_reg;
    assign mem_write_address = mem_write_address_reg;
    assign mem_write_data    = mem_write_data_reg;
    assign mem_write_word    = mem_write_word_reg;

endmodule
